>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the pair force checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LJF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LJF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> sv/ljf_pkg.sv
// ----------------------------------------------------------------------------
// Lennard-Jones pair force package
// Word widths and register index codes shared by the block and its checker.
// ----------------------------------------------------------------------------
package ljf_pkg;

  // Coordinate word and fraction width (Q8.24).
  localparam int unsigned COORD_W = 32;
  localparam int unsigned FRAC_W  = 24;

  // Signed coordinate difference.
  localparam int unsigned DIFF_W = COORD_W + 1;
  // Squared distance, sum of three squares.
  localparam int unsigned SQ_W   = 2 * COORD_W + 2;
  // Cutoff square, 25 * sigma^2.
  localparam int unsigned CUT_W  = 2 * COORD_W + 5;
  // Quotient bits of the ratio dividers (values below 4.0).
  localparam int unsigned QU_W   = FRAC_W + 2;

  // Configuration register indexes.
  localparam logic [1:0] REG_BOX   = 2'd0;
  localparam logic [1:0] REG_EPS   = 2'd1;
  localparam logic [1:0] REG_SIGMA = 2'd2;

  // Register reset values: 5.0, 1.0 and 1.0.
  localparam logic [COORD_W-1:0] BOX_RST   = COORD_W'(5) << FRAC_W;
  localparam logic [COORD_W-1:0] EPS_RST   = COORD_W'(1) << FRAC_W;
  localparam logic [COORD_W-1:0] SIGMA_RST = COORD_W'(1) << FRAC_W;

endpackage

>>> sv/lennard_jones_pair_force.sv
// ----------------------------------------------------------------------------
// Lennard-Jones pair force, minimum image
// Pipelined force and potential of one particle pair per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one pair per beat: first x/y/z, then second
// x/y/z, each unsigned Q8.24. The master stream returns force x/y/z on the
// first particle and the pair potential, signed Q8.24 and saturating, with
// tuser set when sigma < r < 2.5*sigma; otherwise the beat is all zeros.
// Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while the
// pipe is empty; derived sigma squares are registered behind sigma, first
// sigma^2 and then 25*sigma^2. The pipe holds the 26-step ratio divider
// and the 32-step force divider, one quotient bit per stage. Throughput
// is one pair per cycle while the output is not stalled.
// All stages advance together whenever the output register is empty or
// taken; while the receiver stalls, one more input beat is caught in a
// skid register and tready then drops until the pipe moves again.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Slave stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [6*ljf_pkg::COORD_W-1:0]     s_axis_tdata_i,
  // Master stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // force_x, force_y, force_z, pair_potential
  output logic [4*ljf_pkg::COORD_W-1:0]     m_axis_tdata_o,
  // in_range
  output logic                              m_axis_tuser_o,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [ljf_pkg::COORD_W-1:0]       cfg_data_i
);

  localparam int unsigned W   = ljf_pkg::COORD_W;
  localparam int unsigned F   = ljf_pkg::FRAC_W;
  localparam int unsigned DW  = ljf_pkg::DIFF_W;
  localparam int unsigned SW  = ljf_pkg::SQ_W;
  localparam int unsigned CW  = ljf_pkg::CUT_W;
  localparam int unsigned QW  = ljf_pkg::QU_W;
  localparam int unsigned NS1 = QW;
  localparam int unsigned NS2 = W;

  // Ratio divider stage: u = sigma^2/r^2 and rho_i = |d_i|/sigma.
  typedef struct packed {
    logic                  vld;
    logic                  rng;
    logic [2:0]            dpos;
    logic [2:0]            dneg;
    logic [SW-1:0]         r2;
    logic [SW-1:0]         rem_u;
    logic [QW-1:0]         q_u;
    logic [QW-1:0]         n_u;
    logic [2:0][W-1:0]     rem_r;
    logic [2:0][QW-1:0]    q_r;
    logic [2:0][QW-1:0]    n_r;
  } div1_t;

  // Power and product stage.
  typedef struct packed {
    logic                  vld;
    logic                  rng;
    logic [2:0]            dpos;
    logic [2:0]            dneg;
    logic [2:0][QW-1:0]    rho;
    logic [F-1:0]          u;
    logic [F-1:0]          u2;
    logic [F-1:0]          u3;
    logic [F-1:0]          u4;
    logic [F-1:0]          u6;
    logic [F-1:0]          u7;
    logic [F-1:0]          gmag;
    logic                  gpos;
    logic                  gneg;
    logic [F-1:0]          pdiff;
    logic [2:0][QW-1:0]    m;
    logic [W+F-1:0]        pp;
    logic [2:0][2*W-1:0]   num;
    logic [W-1:0]          pot;
  } pow_t;

  // Force divider stage: eps*48*m / sigma.
  typedef struct packed {
    logic                  vld;
    logic                  rng;
    logic [2:0]            neg;
    logic [2:0]            sat;
    logic [W-1:0]          pot;
    logic [2:0][W-1:0]     rem;
    logic [2:0][W-1:0]     q;
    logic [2:0][W-1:0]     n;
  } div2_t;

  // One restoring step of the ratio dividers.
  function automatic div1_t div1_step(div1_t x, logic [W-1:0] sig);
    div1_t       y;
    logic [SW:0] tu;
    logic [W:0]  tr;
    y  = x;
    tu = {x.rem_u, x.n_u[QW-1]};
    y.n_u = {x.n_u[QW-2:0], 1'b0};
    if (tu >= {1'b0, x.r2}) begin
      y.rem_u = SW'(tu - {1'b0, x.r2});
      y.q_u   = {x.q_u[QW-2:0], 1'b1};
    end else begin
      y.rem_u = tu[SW-1:0];
      y.q_u   = {x.q_u[QW-2:0], 1'b0};
    end
    for (int i = 0; i < 3; i++) begin
      tr = {x.rem_r[i], x.n_r[i][QW-1]};
      y.n_r[i] = {x.n_r[i][QW-2:0], 1'b0};
      if (tr >= {1'b0, sig}) begin
        y.rem_r[i] = W'(tr - {1'b0, sig});
        y.q_r[i]   = {x.q_r[i][QW-2:0], 1'b1};
      end else begin
        y.rem_r[i] = tr[W-1:0];
        y.q_r[i]   = {x.q_r[i][QW-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  // One restoring step of the force dividers.
  function automatic div2_t div2_step(div2_t x, logic [W-1:0] sig);
    div2_t      y;
    logic [W:0] tr;
    y = x;
    for (int i = 0; i < 3; i++) begin
      tr = {x.rem[i], x.n[i][W-1]};
      y.n[i] = {x.n[i][W-2:0], 1'b0};
      if (tr >= {1'b0, sig}) begin
        y.rem[i] = W'(tr - {1'b0, sig});
        y.q[i]   = {x.q[i][W-2:0], 1'b1};
      end else begin
        y.rem[i] = tr[W-1:0];
        y.q[i]   = {x.q[i][W-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  // Configuration registers and derived sigma squares.
  logic [W-1:0]  box_q, eps_q, sig_q;
  logic [2*W-1:0] s2_q;
  logic [CW-1:0] c2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q <= ljf_pkg::BOX_RST;
      eps_q <= ljf_pkg::EPS_RST;
      sig_q <= ljf_pkg::SIGMA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ljf_pkg::REG_BOX:   box_q <= cfg_data_i;
        ljf_pkg::REG_EPS:   eps_q <= cfg_data_i;
        ljf_pkg::REG_SIGMA: sig_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sigma^2 and 25*sigma^2, each behind its own register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= (2*W)'(1) << (2*F);
      c2_q <= CW'(25) << (2*F);
    end else begin
      s2_q <= (2*W)'(sig_q) * (2*W)'(sig_q);
      c2_q <= (CW'(s2_q) << 4) + (CW'(s2_q) << 3) + CW'(s2_q);
    end
  end

  // Pipe advance and input skid register.
  logic                  adv;
  logic                  out_vld_q;
  logic                  skid_vld_q;
  logic [6*W-1:0]        skid_data_q;
  logic                  s_fire;
  logic                  pin_vld;
  logic [6*W-1:0]        pin_data;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !skid_vld_q;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign pin_vld         = skid_vld_q || s_fire;
  assign pin_data        = skid_vld_q ? skid_data_q : s_axis_tdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (adv) begin
      skid_vld_q <= 1'b0;
    end else if (s_fire) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!adv && s_fire) begin
      skid_data_q <= s_axis_tdata_i;
    end
  end

  // Front stages: difference, fold, magnitude, squares, sum.
  logic                   a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q;
  logic [2:0][DW-1:0]     diff_q, diff_d;
  logic [2:0][DW-1:0]     fold_q, fold_d;
  logic [2:0][W-1:0]      mag_q, mag_d;
  logic [2:0]             dpos_q, dneg_q, dpos_d, dneg_d;
  logic [2:0][2*W-1:0]    sq_q;
  logic [2:0][W-1:0]      mag_dq, mag_eq;
  logic [2:0]             dpos_dq, dneg_dq, dpos_eq, dneg_eq;
  logic [SW-1:0]          r2_q;

  // Coordinate differences, second minus first.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_d[i] = {1'b0, pin_data[(i+3)*W +: W]} - {1'b0, pin_data[i*W +: W]};
    end
  end

  // Minimum-image fold: one correction by the box length.
  logic signed [DW+1:0] dx [3];
  logic signed [DW+1:0] twice [3];
  logic signed [DW+1:0] lenx;
  logic signed [DW+1:0] dn [3];

  always_comb begin
    lenx = $signed({3'b000, box_q});
    for (int i = 0; i < 3; i++) begin
      dx[i]    = $signed({{2{diff_q[i][DW-1]}}, diff_q[i]});
      twice[i] = dx[i] <<< 1;
      if (twice[i] > lenx) begin
        dn[i] = dx[i] - lenx;
      end else if (twice[i] < -lenx) begin
        dn[i] = dx[i] + lenx;
      end else begin
        dn[i] = dx[i];
      end
      fold_d[i] = dn[i][DW-1:0];
    end
  end

  // Magnitude and sign of each folded difference.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dneg_d[i] = fold_q[i][DW-1];
      dpos_d[i] = !fold_q[i][DW-1] && (fold_q[i] != '0);
      mag_d[i]  = fold_q[i][DW-1] ? W'(~fold_q[i] + 1'b1) : fold_q[i][W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= pin_vld;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      diff_q  <= diff_d;
      fold_q  <= fold_d;
      mag_q   <= mag_d;
      dpos_q  <= dpos_d;
      dneg_q  <= dneg_d;
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= (2*W)'(mag_q[i]) * (2*W)'(mag_q[i]);
      end
      mag_dq  <= mag_q;
      dpos_dq <= dpos_q;
      dneg_dq <= dneg_q;
      r2_q    <= SW'(sq_q[0]) + SW'(sq_q[1]) + SW'(sq_q[2]);
      mag_eq  <= mag_dq;
      dpos_eq <= dpos_dq;
      dneg_eq <= dneg_dq;
    end
  end

  // Range test (r^2 > sigma^2 and 4*r^2 < 25*sigma^2) and divider setup.
  div1_t dv1_q [NS1+1];
  div1_t dv1_d [NS1+1];

  always_comb begin
    dv1_d[0]       = '0;
    dv1_d[0].vld   = e_vld_q;
    dv1_d[0].rng   = (r2_q > SW'(s2_q)) && ({1'b0, r2_q, 2'b00} < c2_q);
    dv1_d[0].dpos  = dpos_eq;
    dv1_d[0].dneg  = dneg_eq;
    dv1_d[0].r2    = r2_q;
    dv1_d[0].rem_u = SW'(s2_q >> 2);
    dv1_d[0].n_u   = {s2_q[1:0], {F{1'b0}}};
    for (int i = 0; i < 3; i++) begin
      dv1_d[0].rem_r[i] = W'(mag_eq[i] >> 2);
      dv1_d[0].n_r[i]   = {mag_eq[i][1:0], {F{1'b0}}};
    end
    for (int k = 1; k <= NS1; k++) begin
      dv1_d[k] = div1_step(dv1_q[k-1], sig_q);
    end
  end

  // Powers of u, the force factor and the potential.
  pow_t pw_q [1:7];
  pow_t pw_d [1:7];

  always_comb begin
    logic [2*F-1:0]        pa;
    logic [2*F-1:0]        pb;
    logic signed [F+1:0]   g;
    logic [F+QW-1:0]       pm;
    logic [W+5:0]          m48;
    logic [W+1:0]          pmag;

    // Stage 1: u and u^2.
    pw_d[1]      = '0;
    pw_d[1].vld  = dv1_q[NS1].vld;
    pw_d[1].rng  = dv1_q[NS1].rng;
    pw_d[1].dpos = dv1_q[NS1].dpos;
    pw_d[1].dneg = dv1_q[NS1].dneg;
    pw_d[1].rho  = dv1_q[NS1].q_r;
    pw_d[1].u    = dv1_q[NS1].q_u[F-1:0];
    pa           = (2*F)'(pw_d[1].u) * (2*F)'(pw_d[1].u);
    pw_d[1].u2   = pa[2*F-1:F];

    // Stage 2: u^3 and u^4.
    pw_d[2]    = pw_q[1];
    pa         = (2*F)'(pw_q[1].u2) * (2*F)'(pw_q[1].u);
    pb         = (2*F)'(pw_q[1].u2) * (2*F)'(pw_q[1].u2);
    pw_d[2].u3 = pa[2*F-1:F];
    pw_d[2].u4 = pb[2*F-1:F];

    // Stage 3: u^6.
    pw_d[3]    = pw_q[2];
    pa         = (2*F)'(pw_q[2].u3) * (2*F)'(pw_q[2].u3);
    pw_d[3].u6 = pa[2*F-1:F];

    // Stage 4: u^7.
    pw_d[4]    = pw_q[3];
    pa         = (2*F)'(pw_q[3].u6) * (2*F)'(pw_q[3].u);
    pw_d[4].u7 = pa[2*F-1:F];

    // Stage 5: g = u^7 - u^4/2 and u^3 - u^6.
    pw_d[5]       = pw_q[4];
    g             = $signed({2'b00, pw_q[4].u7}) - $signed({3'b000, pw_q[4].u4[F-1:1]});
    pw_d[5].gneg  = g[F+1];
    pw_d[5].gpos  = !g[F+1] && (g != '0);
    pw_d[5].gmag  = g[F+1] ? F'(-g) : g[F-1:0];
    pw_d[5].pdiff = pw_q[4].u3 - pw_q[4].u6;

    // Stage 6: m_i = |g| * rho_i and eps * (u^3 - u^6).
    pw_d[6] = pw_q[5];
    for (int i = 0; i < 3; i++) begin
      pm            = (F+QW)'(pw_q[5].gmag) * (F+QW)'(pw_q[5].rho[i]);
      pw_d[6].m[i]  = pm[F+QW-1:F];
    end
    pw_d[6].pp = (W+F)'(eps_q) * (W+F)'(pw_q[5].pdiff);

    // Stage 7: numerators eps*48*m_i and the saturated potential.
    pw_d[7] = pw_q[6];
    for (int i = 0; i < 3; i++) begin
      m48            = ((W+6)'(pw_q[6].m[i]) << 5) + ((W+6)'(pw_q[6].m[i]) << 4);
      pw_d[7].num[i] = (2*W)'(eps_q) * (2*W)'(m48[W-1:0]);
    end
    pmag = pw_q[6].pp[W+F-1:F-2];
    if (pmag > (W+2)'(1) << (W-1)) begin
      pw_d[7].pot = W'(1) << (W-1);
    end else begin
      pw_d[7].pot = W'(-pmag);
    end
  end

  // Force divider setup and steps.
  div2_t dv2_q [NS2+1];
  div2_t dv2_d [NS2+1];

  always_comb begin
    dv2_d[0]     = '0;
    dv2_d[0].vld = pw_q[7].vld;
    dv2_d[0].rng = pw_q[7].rng;
    dv2_d[0].pot = pw_q[7].pot;
    for (int i = 0; i < 3; i++) begin
      dv2_d[0].neg[i] = (pw_q[7].gpos && pw_q[7].dpos[i]) ||
                        (pw_q[7].gneg && pw_q[7].dneg[i]);
      dv2_d[0].sat[i] = pw_q[7].num[i][2*W-1:W] >= sig_q;
      dv2_d[0].rem[i] = pw_q[7].num[i][2*W-1:W];
      dv2_d[0].n[i]   = pw_q[7].num[i][W-1:0];
    end
    for (int k = 1; k <= NS2; k++) begin
      dv2_d[k] = div2_step(dv2_q[k-1], sig_q);
    end
  end

  // Pipeline registers; only the valid bits are reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= NS1; k++) dv1_q[k].vld <= 1'b0;
      for (int k = 1; k <= 7; k++)   pw_q[k].vld  <= 1'b0;
      for (int k = 0; k <= NS2; k++) dv2_q[k].vld <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k <= NS1; k++) dv1_q[k] <= dv1_d[k];
      for (int k = 1; k <= 7; k++)   pw_q[k]  <= pw_d[k];
      for (int k = 0; k <= NS2; k++) dv2_q[k] <= dv2_d[k];
    end
  end

  // Sign, saturation and out-of-range zeroing.
  logic [4*W-1:0] out_d, out_data_q;
  logic           out_rng_q;

  always_comb begin
    logic [W-1:0] lim;
    logic [W-1:0] fm;
    out_d = '0;
    for (int i = 0; i < 3; i++) begin
      lim = dv2_q[NS2].neg[i] ? (W'(1) << (W-1)) : ((W'(1) << (W-1)) - 1'b1);
      fm  = (dv2_q[NS2].sat[i] || (dv2_q[NS2].q[i] > lim)) ? lim : dv2_q[NS2].q[i];
      out_d[i*W +: W] = dv2_q[NS2].neg[i] ? W'(-fm) : fm;
    end
    out_d[3*W +: W] = dv2_q[NS2].pot;
    if (!dv2_q[NS2].rng) begin
      out_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv2_q[NS2].vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_d;
      out_rng_q  <= dv2_q[NS2].rng;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_rng_q;

endmodule

>>> sv/ljf_checker.sv
// ----------------------------------------------------------------------------
// Lennard-Jones pair force port checker
// Watches the stream ports of the pair force block over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ljf_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_tready_i,
  input logic                          m_tvalid_i,
  input logic                          m_tready_i,
  input logic [4*ljf_pkg::COORD_W-1:0] m_tdata_i,
  input logic                          m_tuser_i
);

  // A stalled output beat holds its payload.
  `LJF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tuser_i))

  // Out-of-range beats carry all zeros.
  `LJF_ASSERT_IMPL(a_out_zero, clk_i, rst_ni, m_tvalid_i && !m_tuser_i, m_tdata_i == '0)

  // The pair potential is never positive.
  `LJF_ASSERT_IMPL(a_pot_nonpos, clk_i, rst_ni, m_tvalid_i && m_tuser_i, m_tdata_i[4*ljf_pkg::COORD_W-1] || (m_tdata_i[4*ljf_pkg::COORD_W-1:3*ljf_pkg::COORD_W] == '0))

  // Input backpressure only follows a stalled output beat.
  `LJF_ASSERT_IMPL(a_skid_cause, clk_i, rst_ni, !s_tready_i, $past(m_tvalid_i && !m_tready_i))

endmodule

bind lennard_jones_pair_force ljf_checker u_ljf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tuser_i  (m_axis_tuser_o)
);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Lennard-Jones pair force testbench
// Streams particle pairs through the block under several register settings,
// predicts each force and potential beat, and checks every output beat in
// order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 100;

  localparam logic [31:0] ONE      = 32'h0100_0000;
  localparam logic [31:0] ONE_HALF = 32'h0180_0000;
  localparam logic [31:0] TWO_HALF = 32'h0280_0000;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  // Index past the three registers; writes to it have no effect.
  localparam logic [1:0]  REG_NONE = 2'd3;

  typedef struct packed {
    logic [31:0] pot;
    logic [31:0] fz;
    logic [31:0] fy;
    logic [31:0] fx;
    logic        hit;
  } force_beat_t;

  // Holds a copy of the registers and the queue of expected force beats.
  class force_scoreboard;
    logic [31:0] box_len;
    logic [31:0] eps;
    logic [31:0] sigma;
    force_beat_t expected_q[$];
    int unsigned errors;

    function new();
      box_len = ljf_pkg::BOX_RST;
      eps     = ljf_pkg::EPS_RST;
      sigma   = ljf_pkg::SIGMA_RST;
      errors  = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        ljf_pkg::REG_BOX:   box_len = val;
        ljf_pkg::REG_EPS:   eps = val;
        ljf_pkg::REG_SIGMA: sigma = val;
        default: ;
      endcase
    endfunction

    static function logic [63:0] fx_mul(logic [63:0] x, logic [63:0] y);
      logic [127:0] p;
      p = 128'(x) * 128'(y);
      return p[ljf_pkg::FRAC_W +: 64];
    endfunction

    static function logic [31:0] clamp(logic [159:0] mag, bit neg);
      logic [159:0] lim;
      logic [31:0]  m;
      lim = neg ? 160'h8000_0000 : 160'h7FFF_FFFF;
      m = (mag > lim) ? lim[31:0] : mag[31:0];
      return neg ? -m : m;
    endfunction

    // Force on the first particle and pair potential for one pair.
    function force_beat_t pair_force(logic [191:0] pair);
      force_beat_t  res;
      longint       d[3];
      logic [63:0]  dmag[3];
      longint       len;
      logic [159:0] r2, s2, tmp;
      logic [63:0]  u, u2, u3, u4, u6, u7, gmag, rho, m;
      logic [31:0]  fval[3];
      longint       g;
      bit           neg;
      res = '0;
      r2 = '0;
      len = longint'({32'b0, box_len});
      for (int i = 0; i < 3; i++) begin
        d[i] = longint'({32'b0, pair[96+32*i +: 32]}) - longint'({32'b0, pair[32*i +: 32]});
        // Minimum image, folded once.
        if (2 * d[i] > len) d[i] -= len;
        else if (2 * d[i] < -len) d[i] += len;
        dmag[i] = (d[i] < 0) ? 64'(-d[i]) : 64'(d[i]);
        r2 = r2 + 160'(dmag[i]) * 160'(dmag[i]);
      end
      s2 = 160'(sigma) * 160'(sigma);
      if (!(r2 > s2 && 4 * r2 < 25 * s2)) return res;
      tmp = (s2 << ljf_pkg::FRAC_W) / r2;
      u  = tmp[63:0];
      u2 = fx_mul(u, u);
      u3 = fx_mul(u2, u);
      u4 = fx_mul(u2, u2);
      u6 = fx_mul(u3, u3);
      u7 = fx_mul(u6, u);
      g = longint'(u7) - longint'(u4 >> 1);
      gmag = (g < 0) ? 64'(-g) : 64'(g);
      for (int i = 0; i < 3; i++) begin
        tmp = (160'(dmag[i]) << ljf_pkg::FRAC_W) / 160'(sigma);
        rho = tmp[63:0];
        m = fx_mul(gmag, rho);
        tmp = (160'(eps) * 160'(64'(48 * m))) / 160'(sigma);
        neg = (g > 0 && d[i] > 0) || (g < 0 && d[i] < 0);
        fval[i] = clamp(tmp, neg);
      end
      res.fx = fval[0];
      res.fy = fval[1];
      res.fz = fval[2];
      tmp = (160'(eps) * 160'(64'(4 * (u3 - u6)))) >> ljf_pkg::FRAC_W;
      res.pot = clamp(tmp, 1'b1);
      res.hit = 1'b1;
      return res;
    endfunction

    function void note_pair(logic [191:0] pair);
      expected_q.push_back(pair_force(pair));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_beat(logic [127:0] data, logic user);
      force_beat_t want;
      if (expected_q.size() == 0) begin
        report("unexpected beat", data[31:0], '0);
        return;
      end
      want = expected_q.pop_front();
      if (data[31:0] !== want.fx) report("force_x", data[31:0], want.fx);
      if (data[63:32] !== want.fy) report("force_y", data[63:32], want.fy);
      if (data[95:64] !== want.fz) report("force_z", data[95:64], want.fz);
      if (data[127:96] !== want.pot) report("pair_potential", data[127:96], want.pot);
      if (user !== want.hit) report("in_range", 32'(user), 32'(want.hit));
    endtask
  endclass

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [191:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [127:0] m_tdata;
  logic         m_tuser;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_idx = ljf_pkg::REG_BOX;
  logic [31:0]  cfg_data = '0;

  force_scoreboard sb = new();
  bit          quiet = 1'b0;
  int unsigned hold_asked = 0;
  int unsigned hold_done = 0;
  int unsigned hold_left = 0;
  int unsigned cycles = 0;

  lennard_jones_pair_force u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // Clock.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stalls, a long hold-off on request, and the beat check.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
    if (rst_ni && m_tvalid && m_tready) sb.check_beat(m_tdata, m_tuser);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_done != hold_asked) begin
      hold_done <= hold_asked;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 35);
    end
  end

  function automatic logic [191:0] pack_pair(logic [31:0] ax, logic [31:0] ay,
                                             logic [31:0] az, logic [31:0] bx,
                                             logic [31:0] by, logic [31:0] bz);
    return {bz, by, bx, az, ay, ax};
  endfunction

  // A pair inside the box whose separation is within about 1.5 sigma per axis.
  function automatic logic [191:0] near_pair();
    logic [191:0] p;
    longint len, span, a, b;
    len = longint'({32'b0, sb.box_len});
    span = longint'({32'b0, sb.sigma}) * 3 / 2;
    for (int i = 0; i < 3; i++) begin
      a = (len > 0) ? longint'({$urandom, $urandom} % 64'(len))
                    : longint'({32'b0, $urandom});
      b = a + longint'({$urandom, $urandom} % 64'(2 * span + 1)) - span;
      if (len > 0) b = ((b % len) + len) % len;
      p[32*i +: 32] = a[31:0];
      p[96+32*i +: 32] = b[31:0];
    end
    return p;
  endfunction

  task automatic send_pair(input logic [191:0] pair);
    if (!quiet) begin
      while ($urandom_range(99) < 35) begin
        s_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata <= pair;
    do @(posedge clk_i); while (!s_tready);
    sb.note_pair(pair);
  endtask

  // Mostly well-formed near pairs, the rest arbitrary bit patterns.
  task automatic send_random(input int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      if ($urandom_range(99) < 80) send_pair(near_pair());
      else send_pair({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // The derived sigma squares settle after a write, sigma^2 first and then 25*sigma^2.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_regs(input logic [31:0] box, input logic [31:0] e,
                          input logic [31:0] s);
    drain();
    write_reg(ljf_pkg::REG_BOX, box);
    write_reg(ljf_pkg::REG_EPS, e);
    write_reg(ljf_pkg::REG_SIGMA, s);
  endtask

  // Stimulus.
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed pairs at reset settings: box 5, epsilon 1, sigma 1.
    send_pair('0);
    send_pair({6{ALL_ONES}});
    send_pair(pack_pair(0, 0, 0, ALL_ONES, ALL_ONES, ALL_ONES));
    send_pair(pack_pair(0, 0, 0, ONE_HALF, 0, 0));
    send_pair(pack_pair(ONE_HALF, 0, 0, 0, 0, 0));
    send_pair(pack_pair(ONE, ONE, ONE, 2 * ONE, ONE, ONE));
    send_pair(pack_pair(ONE, ONE, ONE, 2 * ONE + 1, ONE, ONE));
    send_pair(pack_pair(0, 0, 0, ONE + 32'h10, 0, 0));
    send_pair(pack_pair(0, 0, 0, TWO_HALF, 0, 0));
    send_pair(pack_pair(0, 0, 0, TWO_HALF - 1, 0, 0));
    send_pair(pack_pair(32'h0033_3333, 0, ONE, 32'h0480_0000, 32'h00E6_6666, ONE));
    send_pair(pack_pair(3 * ONE, ONE, ONE, 2 * ONE, 32'h0233_3333, 32'h004C_CCCC));
    send_pair(pack_pair(0, 0, 0, 32'h0166_6666, 32'h0166_6666, ONE));
    send_pair(pack_pair(32'h0480_0000, 32'h0480_0000, 0, 32'h0080_0000, 0, 0));
    send_random(150);

    // Largest box and epsilon: forces saturate.
    set_regs(ALL_ONES, ALL_ONES, ONE);
    send_random(120);

    // Small sigma, with a long receiver hold-off while the sender keeps going.
    set_regs(32'h0400_0000, 32'h0080_0000, 32'h0040_0000);
    send_random(20);
    hold_asked++;
    send_random(130);

    // Sigma of one LSB.
    set_regs(32'd16, ONE, 32'd1);
    send_random(60);

    // Largest sigma.
    set_regs(ALL_ONES, ALL_ONES, ALL_ONES);
    send_random(100);

    // Zero box, epsilon and sigma: nothing is ever in range.
    set_regs(0, 0, 0);
    write_reg(REG_NONE, ALL_ONES);
    send_random(40);

    // Back to reset values; a full pause, then a stretch with no idling.
    set_regs(ljf_pkg::BOX_RST, ljf_pkg::EPS_RST, ljf_pkg::SIGMA_RST);
    send_random(50);
    drain();
    quiet = 1'b1;
    send_random(100);
    quiet = 1'b0;
    send_random(50);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
